// ===== rtl/core/cfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfpd_pkg - shared types and constants of the framed packet deframer
// Status codes, register indexes and reset values, the job handed from the
// frame parser to the release sequencer, and the CRC-16 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package cfpd_pkg;

  localparam int DEFAULT_FRAME_BUFFER_DEPTH = 64;

  // Longest payload run ever released
  localparam int RUN_LIMIT = 57;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPECTRUM_TYPE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPECTRUM_LENGTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_TYPE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_LENGTH  = 3'd6;

  // Register reset values
  localparam logic [7:0] RST_START_BYTE      = 8'hAA;
  localparam logic [7:0] RST_END_BYTE        = 8'hBB;
  localparam logic [5:0] RST_MAX_PAYLOAD     = 6'd50;
  localparam logic [7:0] RST_SPECTRUM_TYPE   = 8'h01;
  localparam logic [5:0] RST_SPECTRUM_LENGTH = 6'd45;
  localparam logic [7:0] RST_CONTROL_TYPE    = 8'h02;
  localparam logic [5:0] RST_CONTROL_LENGTH  = 6'd5;

  typedef enum logic [2:0] {
    ST_SPECTRUM = 3'd0,
    ST_CONTROL  = 3'd1,
    ST_CRC_ERR  = 3'd2,
    ST_END_ERR  = 3'd3,
    ST_LEN_ERR  = 3'd4,
    ST_BAD_TYPE = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [5:0] max_payload;
    logic [7:0] spectrum_type;
    logic [5:0] spectrum_length;
    logic [7:0] control_type;
    logic [5:0] control_length;
  } cfg_t;

  // One unit of work for the release side: a status item, or a payload run
  typedef struct packed {
    status_t    status;
    logic [7:0] seq;
    logic [5:0] len;
  } job_t;

  // CRC-16-CCITT, MSB first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crc_framed_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// crc_framed_packet_deframer - start/length/end framed packet parser, CRC-16
// Input bytes are taken one per cycle while the job queue has room. A length
// error or an end-byte verdict passes the job queue and the output register;
// a payload run passes the job queue, then a buffer read and an output load for
// each item in turn. Payload bytes of the next frame stall while a run is out.
// Synchronous active-high reset: idle, queue empty, registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_framed_packet_deframer
  import cfpd_pkg::*;
#(
  parameter int FRAME_BUFFER_DEPTH = DEFAULT_FRAME_BUFFER_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Received byte stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
  // Released items
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [23:0]               m_axis_tdata,   // [7:0] data_byte, [13:8] byte_index,
                                                    // [21:14] sequence_res, [23:22] zero
  output logic [2:0]                m_axis_tuser,   // [2:0] status
  output logic                      m_axis_tlast,   // last
  // Configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  localparam int AW = $clog2(FRAME_BUFFER_DEPTH);

  cfg_t          cfg;
  logic          fr_job_valid;
  logic          fr_job_ready;
  job_t          fr_job;
  logic          bk_job_valid;
  logic          bk_job_ready;
  job_t          bk_job;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          run_done;
  status_t       out_status;
  logic [7:0]    out_data;
  logic [5:0]    out_index;
  logic [7:0]    out_seq;

  // Registers take a write every cycle; out-of-list indexes drop the transfer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte      <= RST_START_BYTE;
      cfg.end_byte        <= RST_END_BYTE;
      cfg.max_payload     <= RST_MAX_PAYLOAD;
      cfg.spectrum_type   <= RST_SPECTRUM_TYPE;
      cfg.spectrum_length <= RST_SPECTRUM_LENGTH;
      cfg.control_type    <= RST_CONTROL_TYPE;
      cfg.control_length  <= RST_CONTROL_LENGTH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_BYTE:      cfg.start_byte      <= cfg_data;
        REG_END_BYTE:        cfg.end_byte        <= cfg_data;
        REG_MAX_PAYLOAD:     cfg.max_payload     <= cfg_data[5:0];
        REG_SPECTRUM_TYPE:   cfg.spectrum_type   <= cfg_data;
        REG_SPECTRUM_LENGTH: cfg.spectrum_length <= cfg_data[5:0];
        REG_CONTROL_TYPE:    cfg.control_type    <= cfg_data;
        REG_CONTROL_LENGTH:  cfg.control_length  <= cfg_data[5:0];
        default:             cfg                 <= cfg;
      endcase
    end
  end

  // Front: parse frames, fill the payload buffer, queue at most one job per frame
  cfpd_front #(
    .FRAME_BUFFER_DEPTH(FRAME_BUFFER_DEPTH),
    .AW(AW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .job_valid(fr_job_valid),
    .job_ready(fr_job_ready),
    .job      (fr_job),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .run_done (run_done)
  );

  // Short queue so either side can stall on its own
  cfpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fr_job_valid),
    .push_ready(fr_job_ready),
    .push_job  (fr_job),
    .pop_valid (bk_job_valid),
    .pop_ready (bk_job_ready),
    .pop_job   (bk_job)
  );

  // Back: release a status item or read the buffer out as a payload run
  cfpd_back #(
    .FRAME_BUFFER_DEPTH(FRAME_BUFFER_DEPTH),
    .AW(AW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .job_valid (bk_job_valid),
    .job_ready (bk_job_ready),
    .job       (bk_job),
    .run_done  (run_done),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_status(out_status),
    .out_data  (out_data),
    .out_index (out_index),
    .out_seq   (out_seq),
    .out_last  (m_axis_tlast)
  );

  // Pack the result fields, lowest field first, pad to whole bytes
  assign m_axis_tdata = {2'b00, out_seq, out_index, out_data};
  assign m_axis_tuser = out_status;

endmodule

`default_nettype wire

// ===== rtl/core/cfpd_front.sv =====
// ----------------------------------------------------------------------------
// cfpd_front - frame parser
// Walks the frame fields byte by byte, runs the CRC, writes payload bytes to
// the buffer and queues at most one job per closed or dropped frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpd_front
  import cfpd_pkg::*;
#(
  parameter int FRAME_BUFFER_DEPTH = DEFAULT_FRAME_BUFFER_DEPTH,
  parameter int AW = $clog2(FRAME_BUFFER_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cfg_t          cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  output logic               job_valid,
  input  wire logic          job_ready,
  output job_t               job,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [7:0]         wr_data,
  input  wire logic          run_done
);

  typedef enum logic [2:0] {
    S_IDLE, S_TYPE, S_SEQ, S_LEN, S_PAYLOAD, S_CRC_LO, S_CRC_HI, S_END
  } state_t;

  state_t      state;
  logic [15:0] crc;
  logic [7:0]  frame_type;
  logic [7:0]  seq;
  logic [5:0]  len;
  logic [5:0]  cnt;
  logic [7:0]  crc_lo;
  logic        crc_ok;
  logic        run_pending;
  logic        fire;
  logic        len_bad;
  logic [15:0] crc_next;

  // Hold payload bytes off the buffer while an earlier run still reads it
  assign in_ready = job_ready && !(state == S_PAYLOAD && run_pending);
  assign fire     = in_valid && in_ready;
  assign crc_next = crc16_byte(crc, in_byte);

  assign len_bad = (in_byte > {2'b00, cfg.max_payload}) ||
                   (int'(in_byte) > RUN_LIMIT) ||
                   (int'(in_byte) + 7 > FRAME_BUFFER_DEPTH);

  assign wr_en   = fire && state == S_PAYLOAD;
  assign wr_addr = AW'(cnt);
  assign wr_data = in_byte;

  always_comb begin
    job_valid  = 1'b0;
    job.status = ST_LEN_ERR;
    job.seq    = seq;
    job.len    = len;
    if (fire && state == S_LEN && len_bad) begin
      job_valid = 1'b1;
    end else if (fire && state == S_END) begin
      job_valid = 1'b1;
      if (in_byte != cfg.end_byte) begin
        job.status = ST_END_ERR;
      end else if (!crc_ok) begin
        job.status = ST_CRC_ERR;
      end else if (frame_type == cfg.spectrum_type && len == cfg.spectrum_length) begin
        job.status = ST_SPECTRUM;
        job_valid  = (len != 6'd0);
      end else if (frame_type == cfg.control_type && len == cfg.control_length) begin
        job.status = ST_CONTROL;
        job_valid  = (len != 6'd0);
      end else begin
        job.status = ST_BAD_TYPE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      crc         <= CRC_INIT;
      crc_ok      <= 1'b0;
      run_pending <= 1'b0;
      frame_type  <= '0;
      seq         <= '0;
      len         <= '0;
      cnt         <= '0;
      crc_lo      <= '0;
    end else begin
      if (job_valid && (job.status == ST_SPECTRUM || job.status == ST_CONTROL)) begin
        run_pending <= 1'b1;
      end else if (run_done) begin
        run_pending <= 1'b0;
      end
      if (fire) begin
        unique case (state)
          S_IDLE: begin
            if (in_byte == cfg.start_byte) begin
              state  <= S_TYPE;
              crc    <= CRC_INIT;
              crc_ok <= 1'b0;
            end
          end
          S_TYPE: begin
            frame_type <= in_byte;
            crc        <= crc_next;
            state      <= S_SEQ;
          end
          S_SEQ: begin
            seq   <= in_byte;
            crc   <= crc_next;
            state <= S_LEN;
          end
          S_LEN: begin
            if (len_bad) begin
              state <= S_IDLE;
            end else begin
              len   <= in_byte[5:0];
              crc   <= crc_next;
              cnt   <= '0;
              state <= (in_byte[5:0] == 6'd0) ? S_CRC_LO : S_PAYLOAD;
            end
          end
          S_PAYLOAD: begin
            crc <= crc_next;
            cnt <= cnt + 6'd1;
            if (cnt + 6'd1 == len) begin
              state <= S_CRC_LO;
            end
          end
          S_CRC_LO: begin
            crc_lo <= in_byte;
            state  <= S_CRC_HI;
          end
          S_CRC_HI: begin
            crc_ok <= ({in_byte, crc_lo} == crc);
            state  <= S_END;
          end
          S_END: begin
            state <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cfpd_queue.sv =====
// ----------------------------------------------------------------------------
// cfpd_queue - two-entry job queue
// Decouples the frame parser from the release sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpd_queue
  import cfpd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire job_t push_job,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output job_t      pop_job
);

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cfpd_back.sv =====
// ----------------------------------------------------------------------------
// cfpd_back - release sequencer
// Holds the payload buffer, turns each job into one status item or a run of
// payload items, and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpd_back
  import cfpd_pkg::*;
#(
  parameter int FRAME_BUFFER_DEPTH = DEFAULT_FRAME_BUFFER_DEPTH,
  parameter int AW = $clog2(FRAME_BUFFER_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          job_valid,
  output logic               job_ready,
  input  wire job_t          job,
  output logic               run_done,
  output logic               out_valid,
  input  wire logic          out_ready,
  output status_t            out_status,
  output logic [7:0]         out_data,
  output logic [5:0]         out_index,
  output logic [7:0]         out_seq,
  output logic               out_last
);

  typedef enum logic [1:0] {B_IDLE, B_FETCH, B_EMIT} state_t;

  logic [7:0] mem [FRAME_BUFFER_DEPTH];
  logic [7:0] rd_data;
  state_t     state;
  job_t       cur;
  logic [5:0] idx;
  logic       out_free;
  logic       last_item;
  logic       out_load;

  assign out_free  = !out_valid || out_ready;
  assign job_ready = (state == B_IDLE) && out_free;
  assign last_item = (idx + 6'd1 == cur.len);
  assign run_done  = (state == B_EMIT) && out_free && last_item;

  // Load the output register with a status item or the next payload item
  assign out_load = ((state == B_IDLE) && job_valid && job_ready &&
                     !(job.status == ST_SPECTRUM || job.status == ST_CONTROL)) ||
                    ((state == B_EMIT) && out_free);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state == B_FETCH) begin
      rd_data <= mem[AW'(idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      out_valid  <= 1'b0;
      cur        <= '0;
      idx        <= '0;
      out_status <= ST_SPECTRUM;
      out_data   <= '0;
      out_index  <= '0;
      out_seq    <= '0;
      out_last   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (job_valid && job_ready) begin
            if (job.status == ST_SPECTRUM || job.status == ST_CONTROL) begin
              cur   <= job;
              idx   <= '0;
              state <= B_FETCH;
            end else begin
              out_status <= job.status;
              out_data   <= '0;
              out_index  <= '0;
              out_seq    <= job.seq;
              out_last   <= 1'b1;
            end
          end
        end
        B_FETCH: begin
          state <= B_EMIT;
        end
        B_EMIT: begin
          if (out_free) begin
            out_status <= cur.status;
            out_data   <= rd_data;
            out_index  <= idx;
            out_seq    <= cur.seq;
            out_last   <= last_item;
            idx        <= idx + 6'd1;
            state      <= last_item ? B_IDLE : B_FETCH;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
